FILE: src/ole_pkg.sv
// Package for the ordered list engine.
// Holds field widths, the request and status codes and the result word type.
// No dependencies.
package ole_pkg;

    localparam int VAL_W = 32;
    localparam int OP_W  = 3;
    localparam int POS_W = 7;
    localparam int ST_W  = 3;
    localparam int IDX_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_LOCATE = 3'd3,
        OP_LENGTH = 3'd4,
        OP_MIDDLE = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  value;
        logic [IDX_W-1:0]         index;
        logic [IDX_W-1:0]         length;
        logic                     empty;
    } t_result;

endpackage

FILE: src/ole_store.sv
// Element store of the ordered list engine.
// One write port and one read port, read data registered.
// Depends on ole_pkg.
module ole_store
    import ole_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic signed [VAL_W-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    output logic signed [VAL_W-1:0] o_rd_data
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/ole_seq.sv
// Request sequencer of the ordered list engine.
// Walks the element store one entry a cycle for shift, scan and single reads.
// Depends on ole_pkg; drives the ports of ole_store.
module ole_seq
    import ole_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [OP_W-1:0]         i_op,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_item_value,
    output logic                    o_busy,
    output logic                    o_res_valid,
    output t_result                 o_res,
    input  logic                    i_res_take,
    output logic                    o_rd_en,
    output logic [AW-1:0]           o_rd_addr,
    input  logic signed [VAL_W-1:0] i_rd_data,
    output logic                    o_wr_en,
    output logic [AW-1:0]           o_wr_addr,
    output logic signed [VAL_W-1:0] o_wr_data
);

    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_FILL,
        S_DEL_HEAD,
        S_DEL_SHIFT,
        S_RD_WAIT,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                  r_state,  n_state;
    logic [CW-1:0]           r_count,  n_count;
    logic [AW-1:0]           r_base,   n_base;
    logic [AW-1:0]           r_addr,   n_addr;
    logic signed [VAL_W-1:0] r_val,    n_val;
    t_status                 r_status, n_status;
    logic signed [VAL_W-1:0] r_rval,   n_rval;
    logic [IDX_W-1:0]        r_ridx,   n_ridx;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] addr_nx;
    logic [XW-1:0] mid_x;

    always_comb begin
        pos_x   = XW'(i_position);
        cnt_x   = XW'(r_count);
        addr_nx = XW'(r_addr) + XW'(1);
        mid_x   = cnt_x >> 1;

        n_state  = r_state;
        n_count  = r_count;
        n_base   = r_base;
        n_addr   = r_addr;
        n_val    = r_val;
        n_status = r_status;
        n_rval   = r_rval;
        n_ridx   = r_ridx;

        o_rd_en   = 1'b0;
        o_rd_addr = r_addr;
        o_wr_en   = 1'b0;
        o_wr_addr = r_addr;
        o_wr_data = i_rd_data;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rval   = '0;
                    n_ridx   = '0;
                    n_status = ST_OK;
                    n_val    = i_item_value;
                    n_base   = AW'(pos_x - XW'(1));
                    n_state  = S_DONE;
                    case (t_op'(i_op))
                        OP_INSERT: begin
                            if (cnt_x >= CAP_X) begin
                                n_status = ST_FULL;
                            end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                                n_status = ST_RANGE;
                            end else if (pos_x == cnt_x + XW'(1)) begin
                                n_state = S_INS_FILL;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(cnt_x - XW'(1));
                                n_addr    = AW'(cnt_x - XW'(1));
                                n_state   = S_INS_SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(pos_x - XW'(1));
                                n_addr    = AW'(pos_x - XW'(1));
                                n_state   = S_DEL_HEAD;
                            end
                        end
                        OP_READ: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(pos_x - XW'(1));
                                n_state   = S_RD_WAIT;
                            end
                        end
                        OP_LOCATE: begin
                            if (cnt_x == '0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_addr    = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        OP_LENGTH: begin
                            n_status = ST_OK;
                        end
                        OP_MIDDLE: begin
                            if (cnt_x == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(mid_x);
                                n_ridx    = IDX_W'(mid_x + XW'(1));
                                n_state   = S_RD_WAIT;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_INS_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(addr_nx);
                o_wr_data = i_rd_data;
                if (r_addr == r_base) begin
                    n_state = S_INS_FILL;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_addr - AW'(1);
                    n_addr    = r_addr - AW'(1);
                end
            end
            S_INS_FILL: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_base;
                o_wr_data = r_val;
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
            end
            S_DEL_HEAD: begin
                n_rval = i_rd_data;
                if (addr_nx == cnt_x) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(addr_nx);
                    n_addr    = AW'(addr_nx);
                    n_state   = S_DEL_SHIFT;
                end
            end
            S_DEL_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_addr - AW'(1);
                o_wr_data = i_rd_data;
                if (addr_nx == cnt_x) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(addr_nx);
                    n_addr    = AW'(addr_nx);
                end
            end
            S_RD_WAIT: begin
                n_rval  = i_rd_data;
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (i_rd_data == r_val) begin
                    n_status = ST_OK;
                    n_ridx   = IDX_W'(addr_nx);
                    n_state  = S_DONE;
                end else if (addr_nx == cnt_x) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(addr_nx);
                    n_addr    = AW'(addr_nx);
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
        end
        r_base <= n_base;
        r_addr <= n_addr;
        r_val  <= n_val;
        r_rval <= n_rval;
        r_ridx <= n_ridx;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status = r_status;
        o_res.value  = r_rval;
        o_res.index  = r_ridx;
        o_res.length = IDX_W'(XW'(r_count));
        o_res.empty  = (r_count == '0);
    end

endmodule

FILE: src/ordered_list_engine.sv
// Ordered list engine, top level: sequencer, element store and output register.
// Depends on ole_pkg, ole_seq and ole_store.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit words in a single
// memory with one read and one write port, element 1 at address 0. One request
// is worked at a time; the next is taken once the result has moved into the
// output register, which may still wait on the consumer. Insert at position p
// shifts elements p to n up by one before writing the new one (no shift when
// appending); delete at p shifts the elements after it down by one; locate
// scans from element 1 to a match or the end. The store moves one entry per
// cycle through its read-modify-write path. There is no clearing pass after reset.
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_op,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_item_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ST_W-1:0]         o_status,
    output logic signed [VAL_W-1:0] o_result_value,
    output logic [IDX_W-1:0]        o_result_index,
    output logic [IDX_W-1:0]        o_list_length,
    output logic                    o_is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                    busy;
    logic                    res_valid;
    t_result                 res;
    logic                    res_take;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic signed [VAL_W-1:0] rd_data;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    logic                    r_out_valid;
    t_result                 r_out;

    assign o_in_stall = busy;
    assign res_take   = !r_out_valid || !i_out_stall;

    ole_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_in_valid && !busy),
        .i_op         (i_op),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_busy       (busy),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    ole_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_result_value = r_out.value;
    assign o_result_index = r_out.index;
    assign o_list_length  = r_out.length;
    assign o_is_empty     = r_out.empty;

endmodule

FILE: verif/ordered_list_engine_test.sv
// Self-checking testbench for the ordered list engine: drives list requests over the
// valid/stall channel and checks every result word against a mirrored list.
// Depends on ole_pkg and ordered_list_engine.
`timescale 1ns / 1ps

module ordered_list_engine_test
    import ole_pkg::*;
();

    localparam int CAPACITY    = 64;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 235;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_WAIT  = 80;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int SEND_IDLE [4] = '{0, 70, 0, 26};
    localparam int RECV_STALL [4] = '{0, 0, 70, 26};
    localparam int INSERT_BIAS [PHASES] = '{80, 20, 50, 80, 20, 50, 85, 15};
    localparam logic signed [VAL_W-1:0] HOT_VALUES [5] =
        '{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1};

    class list_scoreboard;
        logic signed [VAL_W-1:0] elems [CAPACITY];
        int                      n_elems;
        t_result                 awaited [$];
        int                      failures;

        function new();
            n_elems  = 0;
            failures = 0;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            t_result res;
            int      p;
            int      i;
            bit      found;
            res        = '0;
            res.status = ST_OK;
            p          = int'(pos);
            case (op)
                OP_INSERT: begin
                    if (n_elems >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else if (p < 1 || p > n_elems + 1) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (i = n_elems; i >= p; i--)
                            elems[i] = elems[i-1];
                        elems[p-1] = val;
                        n_elems++;
                    end
                end
                OP_DELETE: begin
                    if (p < 1 || p > n_elems) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.value = elems[p-1];
                        for (i = p; i < n_elems; i++)
                            elems[i-1] = elems[i];
                        n_elems--;
                    end
                end
                OP_READ: begin
                    if (p < 1 || p > n_elems)
                        res.status = ST_RANGE;
                    else
                        res.value = elems[p-1];
                end
                OP_LOCATE: begin
                    found      = 1'b0;
                    res.status = ST_NOTFOUND;
                    for (i = 0; i < n_elems; i++) begin
                        if (!found && elems[i] == val) begin
                            found      = 1'b1;
                            res.status = ST_OK;
                            res.index  = IDX_W'(i + 1);
                        end
                    end
                end
                OP_LENGTH: begin
                end
                OP_MIDDLE: begin
                    if (n_elems == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.index = IDX_W'(n_elems / 2 + 1);
                        res.value = elems[n_elems / 2];
                    end
                end
                default: res.status = ST_RANGE;
            endcase
            res.length = IDX_W'(n_elems);
            res.empty  = (n_elems == 0);
            awaited.push_back(res);
        endfunction

        function void report(string what, t_result want, t_result got);
            failures++;
            if (failures <= 10)
                $display({"%s: want st %0d val %0d idx %0d len %0d empty %0d,",
                          " got st %0d val %0d idx %0d len %0d empty %0d"},
                         what, want.status, want.value, want.index, want.length,
                         want.empty, got.status, got.value, got.index, got.length,
                         got.empty);
        endfunction

        function void check_result(t_result got);
            t_result want;
            bit      bad;
            if (awaited.size() == 0) begin
                report("unexpected word", '0, got);
                return;
            end
            want = awaited.pop_front();
            bad  = (got.status !== want.status) || (got.value !== want.value)
                || (got.index !== want.index) || (got.length !== want.length)
                || (got.empty !== want.empty);
            if (bad)
                report("word mismatch", want, got);
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [OP_W-1:0]         i_op = OP_LENGTH;
    logic [POS_W-1:0]        i_position = '0;
    logic signed [VAL_W-1:0] i_item_value = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [ST_W-1:0]         o_status;
    logic signed [VAL_W-1:0] o_result_value;
    logic [IDX_W-1:0]        o_result_index;
    logic [IDX_W-1:0]        o_list_length;
    logic                    o_is_empty;

    list_scoreboard sb;
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    int             cycles = 0;

    ordered_list_engine #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_position     (i_position),
        .i_item_value   (i_item_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_result_index (o_result_index),
        .o_list_length  (o_list_length),
        .o_is_empty     (o_is_empty)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_status, o_result_value, o_result_index, o_list_length,
                             o_is_empty});
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic signed [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_position   <= pos;
        i_item_value <= val;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(op, pos, val);
    endtask

    task automatic random_request(int insert_pct);
        int                      r;
        int                      len;
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        len = sb.n_elems;
        r   = $urandom_range(0, 99);
        if (r < 70)
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
        else if (r < 77)
            op = OP_READ;
        else if (r < 88)
            op = OP_LOCATE;
        else if (r < 93)
            op = OP_LENGTH;
        else if (r < 98)
            op = OP_MIDDLE;
        else
            op = r[0] ? OP_SPARE_6 : OP_SPARE_7;

        if ($urandom_range(0, 9) == 0)
            pos = POS_W'($urandom_range(0, 127));
        else if (op == OP_INSERT)
            pos = POS_W'($urandom_range(1, len + 1));
        else
            pos = (len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, len));

        if (op == OP_LOCATE && len > 0 && $urandom_range(0, 1) == 1)
            val = sb.elems[$urandom_range(0, len - 1)];
        else if ($urandom_range(0, 3) == 0)
            val = HOT_VALUES[$urandom_range(0, 4)];
        else
            val = $urandom;
        send_request(op, pos, val);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.awaited.size() != 0);
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_LENGTH, 7'd0, 32'sd0);
        send_request(OP_MIDDLE, 7'd0, 32'sd0);
        send_request(OP_READ, 7'd1, 32'sd0);
        send_request(OP_DELETE, 7'd0, 32'sd0);
        send_request(OP_INSERT, 7'd0, 32'sd5);
        send_request(OP_INSERT, 7'd2, 32'sd5);
        send_request(OP_INSERT, 7'd1, 32'sh7FFF_FFFF);
        send_request(OP_INSERT, 7'd2, 32'sh8000_0000);
        send_request(OP_INSERT, 7'd1, -32'sd1);
        send_request(OP_INSERT, 7'd2, 32'sd0);
        send_request(OP_INSERT, 7'd5, -32'sd1);
        send_request(OP_LOCATE, 7'd0, -32'sd1);
        send_request(OP_LOCATE, 7'd0, 32'sd12345);
        send_request(OP_READ, 7'd127, 32'sd0);
        send_request(OP_READ, 7'd5, 32'sd0);
        send_request(OP_DELETE, 7'd6, 32'sd0);
        send_request(OP_MIDDLE, 7'd0, 32'sd0);
        send_request(OP_SPARE_6, 7'd127, -32'sd1);
        send_request(OP_SPARE_7, 7'd0, 32'sd0);
        send_request(OP_DELETE, 7'd1, 32'sd0);
        send_request(OP_DELETE, 7'd4, 32'sd0);
        send_request(OP_INSERT, 7'd127, 32'sd7);
        send_request(OP_MIDDLE, 7'd0, 32'sd0);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            send_idle_pct = SEND_IDLE[phase % 4];
            stall_pct     = RECV_STALL[phase % 4];
            repeat (PHASE_ITEMS)
                random_request(INSERT_BIAS[phase]);
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.failures == 0 && sb.awaited.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
